// ===== sv/gfrac_pkg.sv =====
// Package for the GF(2^8) recurrent affine cipher.
// Holds widths, register indexes, the sequencer state type and the reduction polynomial.
// No dependencies.
`default_nettype none

package gfrac_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 4;

    // x^8 + x^4 + x^3 + x + 1, low byte only (the x^8 term is implied)
    localparam logic [BYTE_W-1:0] RED_POLY_LO = 8'h1B;

    // Last step of the x^254 addition chain (13 multiplies, steps 0..12)
    localparam logic [STEP_W-1:0] INV_LAST_STEP = 4'd12;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_MULT_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MULT_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ADD_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ADD_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_MULT,
        ST_KEY_ADD,
        ST_INV,
        ST_DATA
    } seq_state_t;

endpackage

`default_nettype wire

// ===== sv/gfrac_mul.sv =====
// Combinational GF(2^8) multiplier, reduction by 0x11B.
// Shared unit of the cipher sequencer; uses gfrac_pkg.
`default_nettype none

module gfrac_mul
    import gfrac_pkg::*;
(
    input  wire logic [BYTE_W-1:0] op_a,
    input  wire logic [BYTE_W-1:0] op_b,
    output logic      [BYTE_W-1:0] prod
);

    always_comb
    begin
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] m;
        acc = '0;
        m   = op_a;
        // shift-and-add, reducing the multiplicand each step (xtime)
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (op_b[i])
            begin
                acc = acc ^ m;
            end
            m = {m[BYTE_W-2:0], 1'b0} ^ (m[BYTE_W-1] ? RED_POLY_LO : '0);
        end
        prod = acc;
    end

endmodule

`default_nettype wire

// ===== sv/gf256_recurrent_affine_cipher.sv =====
// An accepted encrypt request passes through KEY_MULT, KEY_ADD and DATA, where it
// waits for a free output slot; a decrypt request also passes through INV (13 extra
// multiplies for the x^254 inverse). Only one byte is in progress at a time, as the
// single shared GF multiplier computes key updates, inverse and data product.
// Reset (rst_n, asynchronous, active low): config back to a=1,1 b=0,0 encrypt, key
// state and byte position cleared, no result pending.
// Top level of the cipher; uses gfrac_pkg and gfrac_mul.
`default_nettype none

module gf256_recurrent_affine_cipher
    import gfrac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]           s_tuser,   // [0] message_start
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [BYTE_W-1:0]    m_tdata    // [7:0] result_byte
);

    logic [BYTE_W-1:0] key_mult_first_reg, key_mult_second_reg;
    logic [BYTE_W-1:0] key_add_first_reg, key_add_second_reg;
    logic              decrypt_mode_reg;

    logic [BYTE_W-1:0] mult_older_reg, mult_newer_reg;
    logic [BYTE_W-1:0] add_older_reg, add_newer_reg;
    logic [1:0]        pos_reg;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              mode_reg;
    logic [BYTE_W-1:0] a_reg, b_reg, pow_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic [BYTE_W-1:0] op_a, op_b, prod;
    logic              in_accept;
    logic              out_free;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    gfrac_mul u_mul (
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Operand select for the shared multiplier
    always_comb
    begin
        op_a = mult_newer_reg;
        op_b = mult_older_reg;
        case (state_reg)
            ST_KEY_MULT:
            begin
                op_a = mult_newer_reg;
                op_b = mult_older_reg;
            end
            ST_KEY_ADD:
            begin
                op_a = add_newer_reg;
                op_b = add_older_reg;
            end
            ST_INV:
            begin
                // even steps square, odd steps multiply by a
                op_a = pow_reg;
                op_b = step_reg[0] ? a_reg : pow_reg;
            end
            ST_DATA:
            begin
                if (mode_reg)
                begin
                    op_a = data_reg ^ b_reg;
                    op_b = pow_reg;
                end
                else
                begin
                    op_a = a_reg;
                    op_b = data_reg;
                end
            end
            default:
            begin
                op_a = mult_newer_reg;
                op_b = mult_older_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     state_next = in_accept ? ST_KEY_MULT : ST_IDLE;
            ST_KEY_MULT: state_next = ST_KEY_ADD;
            ST_KEY_ADD:  state_next = mode_reg ? ST_INV : ST_DATA;
            ST_INV:      state_next = (step_reg == INV_LAST_STEP) ? ST_DATA : ST_INV;
            ST_DATA:     state_next = out_free ? ST_IDLE : ST_DATA;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mult_first_reg  <= 8'd1;
            key_mult_second_reg <= 8'd1;
            key_add_first_reg   <= '0;
            key_add_second_reg  <= '0;
            decrypt_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_MULT_FIRST:  key_mult_first_reg  <= cfg_data;
                REG_KEY_MULT_SECOND: key_mult_second_reg <= cfg_data;
                REG_KEY_ADD_FIRST:   key_add_first_reg   <= cfg_data;
                REG_KEY_ADD_SECOND:  key_add_second_reg  <= cfg_data;
                REG_DECRYPT_MODE:    decrypt_mode_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Key state and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_older_reg <= '0;
            mult_newer_reg <= '0;
            add_older_reg  <= '0;
            add_newer_reg  <= '0;
            pos_reg        <= POS_FIRST;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // start flag reloads the keys from config
                    if (in_accept && s_tuser[0])
                    begin
                        mult_older_reg <= key_mult_first_reg;
                        mult_newer_reg <= key_mult_second_reg;
                        add_older_reg  <= key_add_first_reg;
                        add_newer_reg  <= key_add_second_reg;
                        pos_reg        <= POS_FIRST;
                    end
                end
                ST_KEY_MULT:
                begin
                    if (pos_reg == POS_LATER)
                    begin
                        mult_older_reg <= mult_newer_reg;
                        mult_newer_reg <= prod;
                    end
                end
                ST_KEY_ADD:
                begin
                    if (pos_reg == POS_LATER)
                    begin
                        add_older_reg <= add_newer_reg;
                        add_newer_reg <= prod;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the current byte
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    data_reg <= s_tdata;
                    mode_reg <= decrypt_mode_reg;
                end
            end
            ST_KEY_MULT:
            begin
                case (pos_reg)
                    POS_FIRST:  a_reg <= mult_older_reg;
                    POS_SECOND: a_reg <= mult_newer_reg;
                    default:    a_reg <= prod;
                endcase
            end
            ST_KEY_ADD:
            begin
                case (pos_reg)
                    POS_FIRST:  b_reg <= add_older_reg;
                    POS_SECOND: b_reg <= add_newer_reg;
                    default:    b_reg <= prod;
                endcase
                pow_reg <= a_reg;
            end
            ST_INV:
            begin
                pow_reg <= prod;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (state_reg == ST_INV)
        begin
            step_reg <= step_reg + 4'd1;
        end
        else
        begin
            step_reg <= '0;
        end
    end

    // Output register: load when the result slot is free, drop once the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DATA && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DATA && out_free)
        begin
            out_data_reg <= mode_reg ? prod : (prod ^ b_reg);
        end
    end

endmodule

`default_nettype wire

// ===== sv/gfrac_checker.sv =====
// Port-level checker for the cipher top level, attached by bind.
// Uses gfrac_pkg for widths.
`default_nettype none

module gfrac_checker
    import gfrac_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [BYTE_W-1:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one byte in flight: not ready through the first sequencer states after a byte is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("request taken while byte in progress");

    // a new result only appears at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a byte in progress");

endmodule

bind gf256_recurrent_affine_cipher gfrac_checker u_gfrac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
